// File: hdl/lud_pkg.sv
// ----------------------------------------------------------------------------
// Lens undistortion remap package
// Shared constants, register indexes and a saturation helper.
// ----------------------------------------------------------------------------
package lud_pkg;

   typedef enum logic [2:0] {
      CSR_FOCAL_X       = 3'd0,
      CSR_FOCAL_Y       = 3'd1,
      CSR_CENTER_X      = 3'd2,
      CSR_CENTER_Y      = 3'd3,
      CSR_RADIAL_K1     = 3'd4,
      CSR_RADIAL_K2     = 3'd5,
      CSR_TANGENTIAL_P1 = 3'd6,
      CSR_TANGENTIAL_P2 = 3'd7
   } csr_index_type;

   localparam logic signed [63:0] Q_MAX_W = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN_W = -64'sd2147483648;
   localparam logic signed [31:0] Q_ONE   = 32'sd1048576;

   // Clamps a wide signed value to the signed Q12.20 range.
   function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > Q_MAX_W) begin
         r = 32'sh7fffffff;
      end else if (v < Q_MIN_W) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/lud_div.sv
// ----------------------------------------------------------------------------
// Lens undistortion pipelined divider
// Computes sat((num * 2^20) / den), truncated toward zero, one quotient bit
// per register stage.
// ----------------------------------------------------------------------------
module lud_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [23:0] num,
   input  logic [23:0]        den,
   output logic               out_valid,
   output logic signed [31:0] quo
);
   import lud_pkg::*;

   localparam int STEPS = 32;

   logic        val_ff [0:STEPS];
   logic        neg_ff [0:STEPS];
   logic        ovf_ff [0:STEPS];
   logic [41:0] rem_ff [0:STEPS];
   logic [31:0] q_ff   [0:STEPS];

   logic [23:0] mag;
   logic        ovf_in;

   // The user must hold the divisor static while items are in flight; the divider does not enforce it.
   always_comb begin
      mag    = num[23] ? 24'(-num) : num;
      ovf_in = 36'(mag) >= {den, 12'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num[23];
         ovf_ff[0] <= ovf_in;
         rem_ff[0] <= {mag[21:0], 20'b0};
         q_ff[0]   <= '0;
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam int SH = STEPS - 1 - s;
      logic [55:0] lhs;
      logic [55:0] rhs;
      logic [41:0] rem_in;
      logic [31:0] q_in;

      always_comb begin
         lhs    = 56'(rem_ff[s]);
         rhs    = 56'(den) << SH;
         rem_in = rem_ff[s];
         q_in   = q_ff[s];
         if (lhs >= rhs) begin
            rem_in   = 42'(lhs - rhs);
            q_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s+1] <= 1'b0;
         end else if (en) begin
            val_ff[s+1] <= val_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            rem_ff[s+1] <= rem_in;
            q_ff[s+1]   <= q_in;
         end
      end
   end

   logic signed [31:0] quo_in;
   logic signed [31:0] quo_ff;
   logic               out_valid_ff;

   always_comb begin
      quo_in = sat_q(64'(q_ff[STEPS]));
      if (neg_ff[STEPS]) begin
         quo_in = sat_q(-64'(q_ff[STEPS]));
      end
      if (ovf_ff[STEPS]) begin
         quo_in = neg_ff[STEPS] ? 32'sh80000000 : 32'sh7fffffff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= val_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign quo       = quo_ff;

endmodule

// File: hdl/lens_undistortion_remap_address_core.sv
// ----------------------------------------------------------------------------
// Lens undistortion remap address core
// Maps an output pixel coordinate to its Brown-Conrady distorted source pixel.
// ----------------------------------------------------------------------------
// The core takes one output pixel coordinate per transfer and returns one
// result transfer per coordinate, in order: the truncated source column and
// row in the distorted image and an in-frame flag (column and row are zero
// when the flag is clear). It accepts a new coordinate in every clock cycle
// while req_stall is low; each one passes through the pair of pipelined
// dividers that normalise the coordinate (one quotient bit per stage),
// eight stages of multiply and add for the distortion polynomial and the
// mapping back to pixels, and the output register. The whole pipeline
// halts as one while a result waits on rsp_stall, so nothing is lost or
// repeated. The user must write registers through the csr port only while
// the core is idle; the core itself does not enforce it.
module lens_undistortion_remap_address_core #(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_out_col,
   input  logic [11:0] req_out_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_src_col,
   output logic [11:0] rsp_src_row,
   output logic        rsp_in_frame,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import lud_pkg::*;

   localparam logic signed [37:0] COL_LIMIT = 38'(IMAGE_WIDTH) * 38'sd1024;
   localparam logic signed [37:0] ROW_LIMIT = 38'(IMAGE_HEIGHT) * 38'sd1024;

   // Configuration registers.
   logic [23:0]        focal_x_ff, focal_y_ff;
   logic [21:0]        center_x_ff, center_y_ff;
   logic signed [23:0] k1_ff, k2_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 24'd1048576;
         focal_y_ff  <= 24'd1048576;
         center_x_ff <= 22'd524288;
         center_y_ff <= 22'd524288;
         k1_ff       <= '0;
         k2_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FOCAL_X:       focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:       focal_y_ff  <= csr_wdata;
            CSR_CENTER_X:      center_x_ff <= csr_wdata[21:0];
            CSR_CENTER_Y:      center_y_ff <= csr_wdata[21:0];
            CSR_RADIAL_K1:     k1_ff       <= csr_wdata;
            CSR_RADIAL_K2:     k2_ff       <= csr_wdata;
            CSR_TANGENTIAL_P1: p1_ff       <= csr_wdata;
            CSR_TANGENTIAL_P2: p2_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline advances unless a finished result is held by the receiver.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Normalisation: offset from the principal point, divided by the focal
   // length. A zero focal length is taken as the smallest step.
   logic signed [23:0] dx, dy;
   logic [23:0]        fx_div, fy_div;
   logic               dv;
   logic signed [31:0] x0, y0;

   assign dx     = signed'({2'b0, req_out_col, 10'b0}) - signed'({2'b0, center_x_ff});
   assign dy     = signed'({2'b0, req_out_row, 10'b0}) - signed'({2'b0, center_y_ff});
   assign fx_div = (focal_x_ff == '0) ? 24'd1 : focal_x_ff;
   assign fy_div = (focal_y_ff == '0) ? 24'd1 : focal_y_ff;

   lud_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .num      (dx),
      .den      (fx_div),
      .out_valid(dv),
      .quo      (x0)
   );

   lud_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .num      (dy),
      .den      (fy_div),
      .out_valid(),
      .quo      (y0)
   );

   // Valid bits of the eight arithmetic stages.
   logic [8:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:1], dv};
      end
   end

   // Stage 1: squares and cross product.
   logic signed [63:0] xx_p, yy_p, xy_p;
   logic signed [31:0] x1_ff, y1_ff, xx1_ff, yy1_ff, xy1_ff;
   assign xx_p = x0 * x0;
   assign yy_p = y0 * y0;
   assign xy_p = x0 * y0;

   // Stage 2: squared radius.
   logic signed [31:0] x2_ff, y2_ff, xx2_ff, yy2_ff, xy2_ff, r2_2_ff;

   // Stage 3: fourth power, first radial term, tangential operands.
   logic signed [63:0] r4_p;
   logic signed [55:0] k1r2_p, p1xy_p, p2xy_p;
   logic signed [31:0] x3_ff, y3_ff, r4_3_ff, tx3_ff, ty3_ff;
   logic signed [33:0] k1r2_3_ff;
   logic signed [34:0] pxy1_3_ff, pxy2_3_ff;
   assign r4_p   = r2_2_ff * r2_2_ff;
   assign k1r2_p = k1_ff * r2_2_ff;
   assign p1xy_p = p1_ff * xy2_ff;
   assign p2xy_p = p2_ff * xy2_ff;

   // Stage 4: remaining coefficient products.
   logic signed [55:0] k2r4_p, p2tx_p, p1ty_p;
   logic signed [31:0] x4_ff, y4_ff;
   logic signed [33:0] k1r2_4_ff, k2r4_4_ff, p2tx_4_ff, p1ty_4_ff;
   logic signed [34:0] pxy1_4_ff, pxy2_4_ff;
   assign k2r4_p = k2_ff * r4_3_ff;
   assign p2tx_p = p2_ff * tx3_ff;
   assign p1ty_p = p1_ff * ty3_ff;

   // Stage 5: radial factor and tangential sums.
   logic signed [31:0] x5_ff, y5_ff, rad5_ff;
   logic signed [35:0] sx5_ff, sy5_ff;

   // Stage 6: radial scaling.
   logic signed [63:0] xr_p, yr_p;
   logic signed [31:0] xr6_ff, yr6_ff;
   logic signed [35:0] sx6_ff, sy6_ff;
   assign xr_p = x5_ff * rad5_ff;
   assign yr_p = y5_ff * rad5_ff;

   // Stage 7: distorted normalised position.
   logic signed [31:0] xd7_ff, yd7_ff;

   // Stage 8: back to pixel units in Q.10.
   logic signed [56:0] uc_p, vr_p;
   logic signed [37:0] uc8_ff, vr8_ff;
   assign uc_p = signed'({1'b0, focal_x_ff}) * xd7_ff;
   assign vr_p = signed'({1'b0, focal_y_ff}) * yd7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= x0;
         y1_ff  <= y0;
         xx1_ff <= sat_q(xx_p >>> 20);
         yy1_ff <= sat_q(yy_p >>> 20);
         xy1_ff <= sat_q(xy_p >>> 20);

         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         xx2_ff  <= xx1_ff;
         yy2_ff  <= yy1_ff;
         xy2_ff  <= xy1_ff;
         r2_2_ff <= sat_q(64'(xx1_ff) + 64'(yy1_ff));

         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         r4_3_ff   <= sat_q(r4_p >>> 20);
         k1r2_3_ff <= k1r2_p[55:22];
         tx3_ff    <= sat_q(64'(r2_2_ff) + 64'(xx2_ff) + 64'(xx2_ff));
         ty3_ff    <= sat_q(64'(r2_2_ff) + 64'(yy2_ff) + 64'(yy2_ff));
         // Doubling the coefficient is one bit less of shift.
         pxy1_3_ff <= p1xy_p[55:21];
         pxy2_3_ff <= p2xy_p[55:21];

         x4_ff     <= x3_ff;
         y4_ff     <= y3_ff;
         k1r2_4_ff <= k1r2_3_ff;
         k2r4_4_ff <= k2r4_p[55:22];
         p2tx_4_ff <= p2tx_p[55:22];
         p1ty_4_ff <= p1ty_p[55:22];
         pxy1_4_ff <= pxy1_3_ff;
         pxy2_4_ff <= pxy2_3_ff;

         x5_ff   <= x4_ff;
         y5_ff   <= y4_ff;
         rad5_ff <= sat_q(64'(Q_ONE) + 64'(k1r2_4_ff) + 64'(k2r4_4_ff));
         sx5_ff  <= 36'(pxy1_4_ff) + 36'(p2tx_4_ff);
         sy5_ff  <= 36'(p1ty_4_ff) + 36'(pxy2_4_ff);

         xr6_ff <= sat_q(xr_p >>> 20);
         yr6_ff <= sat_q(yr_p >>> 20);
         sx6_ff <= sx5_ff;
         sy6_ff <= sy5_ff;

         xd7_ff <= sat_q(64'(xr6_ff) + 64'(sx6_ff));
         yd7_ff <= sat_q(64'(yr6_ff) + 64'(sy6_ff));

         uc8_ff <= 38'(signed'(uc_p[56:20])) + 38'(signed'({1'b0, center_x_ff}));
         vr8_ff <= 38'(signed'(vr_p[56:20])) + 38'(signed'({1'b0, center_y_ff}));
      end
   end

   // Output register: frame test and truncation to whole pixels.
   logic        in_image;
   logic        rsp_valid_ff, in_frame_ff;
   logic [11:0] src_col_ff, src_row_ff;

   assign in_image = (uc8_ff >= 38'sd0) && (vr8_ff >= 38'sd0) &&
                     (uc8_ff < COL_LIMIT) && (vr8_ff < ROW_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[8];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_frame_ff <= in_image;
         src_col_ff  <= in_image ? uc8_ff[21:10] : 12'd0;
         src_row_ff  <= in_image ? vr8_ff[21:10] : 12'd0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_src_col  = src_col_ff;
   assign rsp_src_row  = src_row_ff;
   assign rsp_in_frame = in_frame_ff;

endmodule
